FILE: design/ild_pkg.sv
// Shared types, constants and decode functions of the x86 instruction length decoder.
// Holds the one-byte and two-byte opcode class tables; depends on nothing.
`default_nettype none
package ild_pkg;

    localparam int MAX_INSTR_BYTES = 15;

    localparam int F_MR   = 0;
    localparam int F_I8   = 1;
    localparam int F_I16  = 2;
    localparam int F_IZ   = 3;
    localparam int F_RB   = 4;
    localparam int F_P66  = 5;
    localparam int F_P67  = 6;
    localparam int F_LOCK = 7;
    localparam int F_REP  = 8;
    localparam int F_SEG  = 9;
    localparam int F_TWO  = 10;
    localparam int F_OVER = 11;

    localparam logic [7:0] B_CS   = 8'h2E;
    localparam logic [7:0] B_SS   = 8'h36;
    localparam logic [7:0] B_DS   = 8'h3E;
    localparam logic [7:0] B_ES   = 8'h26;
    localparam logic [7:0] B_FS   = 8'h64;
    localparam logic [7:0] B_GS   = 8'h65;
    localparam logic [7:0] B_LOCK = 8'hF0;
    localparam logic [7:0] B_P66  = 8'h66;
    localparam logic [7:0] B_P67  = 8'h67;
    localparam logic [7:0] B_REPM = 8'hFE;
    localparam logic [7:0] B_REP  = 8'hF2;
    localparam logic [7:0] B_ESC  = 8'h0F;
    localparam logic [7:0] B_TEST8 = 8'hF6;
    localparam logic [7:0] B_TESTZ = 8'hF7;
    localparam logic [7:0] B_GRP5  = 8'hFF;
    localparam logic [7:0] B_MOFFS_LO = 8'hA0;
    localparam logic [7:0] B_MOFFS_HI = 8'hA3;

    localparam logic [4:0] X0 = 5'd0;
    localparam logic [4:0] X1 = 5'd1;
    localparam logic [4:0] X2 = 5'd2;
    localparam logic [4:0] X4 = 5'd4;
    localparam logic [4:0] X8 = 5'd8;
    localparam logic [4:0] MB = 5'd3;
    localparam logic [4:0] MZ = 5'd9;
    localparam logic [4:0] BR = 5'd18;
    localparam logic [4:0] ZR = 5'd24;
    localparam logic [4:0] ZW = 5'd12;
    localparam logic [4:0] WB = 5'd6;

    localparam logic [4:0] ONE_CLS [256] = '{
        X1,X1,X1,X1,X2,X8,X0,X0, X1,X1,X1,X1,X2,X8,X0,X0,
        X1,X1,X1,X1,X2,X8,X0,X0, X1,X1,X1,X1,X2,X8,X0,X0,
        X1,X1,X1,X1,X2,X8,X0,X0, X1,X1,X1,X1,X2,X8,X0,X0,
        X1,X1,X1,X1,X2,X8,X0,X0, X1,X1,X1,X1,X2,X8,X0,X0,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X0,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X0,
        X0,X0,X1,X1,X0,X0,X0,X0, X8,MZ,X2,MB,X0,X0,X0,X0,
        BR,BR,BR,BR,BR,BR,BR,BR, BR,BR,BR,BR,BR,BR,BR,BR,
        MB,MZ,MB,MB,X1,X1,X1,X1, X1,X1,X1,X1,X1,X1,X1,X1,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,ZW,X0,X0,X0,X0,X0,
        X8,X8,X8,X8,X0,X0,X0,X0, X2,X8,X0,X0,X0,X0,X0,X0,
        X2,X2,X2,X2,X2,X2,X2,X2, X8,X8,X8,X8,X8,X8,X8,X8,
        MB,MB,X4,X0,X1,X1,MB,MZ, WB,X0,X4,X0,X0,X2,X0,X0,
        X1,X1,X1,X1,X2,X2,X0,X0, X1,X1,X1,X1,X1,X1,X1,X1,
        BR,BR,BR,BR,X2,X2,X2,X2, ZR,ZR,ZW,BR,X0,X0,X0,X0,
        X0,X0,X0,X0,X0,X0,X1,X1, X0,X0,X0,X0,X0,X0,X1,X1
    };

    localparam logic [4:0] TWO_CLS [256] = '{
        X1,X1,X1,X1,X0,X0,X0,X0, X0,X0,X0,X0,X0,X1,X0,X0,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X1,
        X1,X1,X1,X1,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X0,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X0,
        X1,X1,X1,X1,X1,X1,X1,X1, X1,X1,X1,X1,X1,X1,X1,X1,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X0,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X0,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X0,
        ZR,ZR,ZR,ZR,ZR,ZR,ZR,ZR, ZR,ZR,ZR,ZR,ZR,ZR,ZR,ZR,
        X1,X1,X1,X1,X1,X1,X1,X1, X1,X1,X1,X1,X1,X1,X1,X1,
        X0,X0,X0,X1,MB,X1,X0,X0, X0,X0,X0,X1,MB,X1,X0,X1,
        X1,X1,X1,X1,X1,X1,X1,X1, X0,X0,MB,X1,X1,X1,X1,X1,
        X1,X1,X0,X0,X0,X0,X0,X1, X0,X0,X0,X0,X0,X0,X0,X0,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X0,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X0,
        X0,X0,X0,X0,X0,X0,X0,X0, X0,X0,X0,X0,X0,X0,X0,X0
    };

    typedef struct packed {
        logic [7:0] code;
        logic [4:0] cls1;
        logic [4:0] cls2;
    } t_qent;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qout;

    function automatic logic sib_present(input logic [11:0] flags, input logic [1:0] size,
                                         input logic [7:0] modrm);
        return flags[F_MR] && !size[1] && (modrm[2:0] == 3'd4) && (modrm[7:6] != 2'd3);
    endfunction

    function automatic logic [2:0] disp_total(input logic [11:0] flags, input logic [1:0] size,
                                              input logic [7:0] modrm, input logic [7:0] sib);
        logic [2:0] n;
        logic       a16;
        n   = 3'd0;
        a16 = size[1];
        if (flags[F_MR]) begin
            case (modrm[7:6])
                2'd0: begin
                    if (a16 && modrm[2:0] == 3'd6) n = 3'd2;
                    if (!a16 && modrm[2:0] == 3'd5) n = 3'd4;
                end
                2'd1: n = 3'd1;
                2'd2: n = a16 ? 3'd2 : 3'd4;
                default: n = 3'd0;
            endcase
            if (sib_present(flags, size, modrm) && sib[2:0] == 3'd5 && modrm[7:6] == 2'd0) begin
                n = 3'd4;
            end
        end
        return n;
    endfunction

    function automatic logic [2:0] imm_total(input logic [11:0] flags, input logic [1:0] size,
                                             input logic [7:0] opcode);
        logic [2:0] n;
        logic       narrow;
        narrow = size[0];
        if (!flags[F_TWO] && opcode >= B_MOFFS_LO && opcode <= B_MOFFS_HI) narrow = size[1];
        n = 3'd0;
        if (flags[F_I8]) n = n + 3'd1;
        if (flags[F_I16]) n = n + 3'd2;
        if (flags[F_IZ]) n = n + (narrow ? 3'd2 : 3'd4);
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: design/ild_front.sv
// Front part: takes code bytes, looks up both opcode class tables and queues the item.
// Uses ild_pkg for the class tables and the queue entry type.
`default_nettype none
module ild_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic [7:0]     i_code_byte,
    output ild_pkg::t_qout      o_q,
    input  wire logic           i_pop
);
    ild_pkg::t_qent r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q.valid  = (r_cnt != 2'd0);
    assign o_q.ent    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp].code <= i_code_byte;
            r_mem[r_wp].cls1 <= ild_pkg::ONE_CLS[i_code_byte];
            r_mem[r_wp].cls2 <= ild_pkg::TWO_CLS[i_code_byte];
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

FILE: design/ild_back.sv
// Back part: the prefix, opcode, ModRM, SIB, displacement and immediate sequencer
// with the output register. Uses ild_pkg for flags, constants and length functions.
`default_nettype none
module ild_back #(
    parameter int MAX_INSTR_BYTES = ild_pkg::MAX_INSTR_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire ild_pkg::t_qout i_q,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_instr_length,
    output logic [11:0]      o_decode_flags,
    output logic [2:0]       o_disp_length,
    output logic [2:0]       o_imm_length,
    output logic [7:0]       o_seg_prefix,
    output logic [7:0]       o_rep_prefix,
    output logic [7:0]       o_first_opcode,
    output logic [7:0]       o_second_opcode,
    output logic [7:0]       o_modrm_byte,
    output logic [7:0]       o_sib_byte,
    output logic [31:0]      o_disp_bytes,
    output logic [47:0]      o_imm_bytes
);
    typedef enum logic [2:0] {
        PH_OPC, PH_OPC2, PH_MODRM, PH_SIB, PH_DISP, PH_IMM
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [11:0] r_flags, n_flags;
    logic [3:0]  r_count, n_count;
    logic [7:0]  r_seg, n_seg, r_rep, n_rep, r_opc, n_opc, r_opc2, n_opc2;
    logic [7:0]  r_modrm, n_modrm, r_sib, n_sib;
    logic [31:0] r_disp, n_disp;
    logic [47:0] r_imm, n_imm;
    logic [2:0]  r_drem, n_drem, r_irem, n_irem;
    logic [1:0]  r_size, n_size;
    logic        r_ovalid, n_ovalid;
    logic        done, tail;
    logic [2:0]  dl, il, iidx;
    logic [1:0]  didx;
    logic [7:0]  b;

    assign o_pop       = i_q.valid && (!r_ovalid || !i_out_stall);
    assign o_out_valid = r_ovalid;
    assign b           = i_q.ent.code;

    always_comb begin
        n_phase = r_phase; n_flags = r_flags; n_count = r_count;
        n_seg = r_seg; n_rep = r_rep; n_opc = r_opc; n_opc2 = r_opc2;
        n_modrm = r_modrm; n_sib = r_sib; n_disp = r_disp; n_imm = r_imm;
        n_drem = r_drem; n_irem = r_irem; n_size = r_size;
        n_ovalid = r_ovalid && i_out_stall;
        done = 1'b0; tail = 1'b0; dl = 3'd0; il = 3'd0;
        didx = 2'd0; iidx = 3'd0;
        if (o_pop) begin
            n_count = r_count + 4'd1;
            case (r_phase)
                PH_OPC: begin
                    if (b == ild_pkg::B_P66) begin
                        n_flags[ild_pkg::F_P66] = 1'b1; n_size[0] = 1'b1;
                    end else if (b == ild_pkg::B_P67) begin
                        n_flags[ild_pkg::F_P67] = 1'b1; n_size[1] = 1'b1;
                    end else if (b == ild_pkg::B_LOCK) begin
                        n_flags[ild_pkg::F_LOCK] = 1'b1;
                    end else if ((b & ild_pkg::B_REPM) == ild_pkg::B_REP) begin
                        n_flags[ild_pkg::F_REP] = 1'b1; n_rep = b;
                    end else if (b == ild_pkg::B_CS || b == ild_pkg::B_SS ||
                                 b == ild_pkg::B_DS || b == ild_pkg::B_ES ||
                                 b == ild_pkg::B_FS || b == ild_pkg::B_GS) begin
                        n_flags[ild_pkg::F_SEG] = 1'b1; n_seg = b;
                    end else if (b == ild_pkg::B_ESC) begin
                        n_opc = b; n_flags[ild_pkg::F_TWO] = 1'b1; n_phase = PH_OPC2;
                    end else begin
                        n_opc   = b;
                        n_flags = n_flags | {7'd0, i_q.ent.cls1};
                        if (n_flags[ild_pkg::F_MR]) n_phase = PH_MODRM;
                        else tail = 1'b1;
                    end
                end
                PH_OPC2: begin
                    n_opc2  = b;
                    n_flags = n_flags | {7'd0, i_q.ent.cls2};
                    if (n_flags[ild_pkg::F_MR]) n_phase = PH_MODRM;
                    else tail = 1'b1;
                end
                PH_MODRM: begin
                    n_modrm = b;
                    if (!r_flags[ild_pkg::F_TWO]) begin
                        if (r_opc == ild_pkg::B_TEST8 && b[5:3] == 3'd0)
                            n_flags[ild_pkg::F_I8] = 1'b1;
                        if (r_opc == ild_pkg::B_TESTZ && b[5:3] == 3'd0)
                            n_flags[ild_pkg::F_IZ] = 1'b1;
                        if (r_opc == ild_pkg::B_GRP5 && (b[5:3] == 3'd2 || b[5:3] == 3'd4))
                            n_flags[ild_pkg::F_RB] = 1'b1;
                    end
                    if (ild_pkg::sib_present(n_flags, n_size, n_modrm)) n_phase = PH_SIB;
                    else tail = 1'b1;
                end
                PH_SIB: begin
                    n_sib = b;
                    tail  = 1'b1;
                end
                PH_DISP: begin
                    didx = 2'(ild_pkg::disp_total(r_flags, r_size, r_modrm, r_sib) - r_drem);
                    for (int k = 0; k < 4; k++) begin
                        if (didx == 2'(k)) n_disp[8*k +: 8] = r_disp[8*k +: 8] | b;
                    end
                    n_drem = r_drem - 3'd1;
                    if (n_drem == 3'd0) begin
                        n_irem = ild_pkg::imm_total(r_flags, r_size, r_opc);
                        if (n_irem != 3'd0) n_phase = PH_IMM;
                        else done = 1'b1;
                    end
                end
                default: begin
                    iidx = ild_pkg::imm_total(r_flags, r_size, r_opc) - r_irem;
                    if (iidx > 3'd5) iidx = 3'd5;
                    for (int k = 0; k < 6; k++) begin
                        if (iidx == 3'(k)) n_imm[8*k +: 8] = r_imm[8*k +: 8] | b;
                    end
                    n_irem = r_irem - 3'd1;
                    if (n_irem == 3'd0) done = 1'b1;
                end
            endcase
            if (tail) begin
                n_drem = ild_pkg::disp_total(n_flags, n_size, n_modrm, n_sib);
                n_irem = ild_pkg::imm_total(n_flags, n_size, n_opc);
                if (n_drem != 3'd0) n_phase = PH_DISP;
                else if (n_irem != 3'd0) n_phase = PH_IMM;
                else done = 1'b1;
            end
            if (done) begin
                dl = ild_pkg::disp_total(n_flags, n_size, n_modrm, n_sib);
                il = ild_pkg::imm_total(n_flags, n_size, n_opc);
            end else if (n_count >= 4'(MAX_INSTR_BYTES)) begin
                n_flags[ild_pkg::F_OVER] = 1'b1;
                done = 1'b1;
            end
            if (done) n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            o_instr_length  <= n_count;
            o_decode_flags  <= n_flags;
            o_disp_length   <= dl;
            o_imm_length    <= il;
            o_seg_prefix    <= n_seg;
            o_rep_prefix    <= n_rep;
            o_first_opcode  <= n_opc;
            o_second_opcode <= n_opc2;
            o_modrm_byte    <= n_modrm;
            o_sib_byte      <= n_sib;
            o_disp_bytes    <= n_disp;
            o_imm_bytes     <= n_imm;
        end
        if (!i_rst_n || done) begin
            r_phase <= PH_OPC; r_flags <= 12'd0; r_count <= 4'd0;
            r_seg <= 8'd0; r_rep <= 8'd0; r_opc <= 8'd0; r_opc2 <= 8'd0;
            r_modrm <= 8'd0; r_sib <= 8'd0; r_disp <= 32'd0; r_imm <= 48'd0;
            r_drem <= 3'd0; r_irem <= 3'd0; r_size <= 2'd0;
        end else begin
            r_phase <= n_phase; r_flags <= n_flags; r_count <= n_count;
            r_seg <= n_seg; r_rep <= n_rep; r_opc <= n_opc; r_opc2 <= n_opc2;
            r_modrm <= n_modrm; r_sib <= n_sib; r_disp <= n_disp; r_imm <= n_imm;
            r_drem <= n_drem; r_irem <= n_irem; r_size <= n_size;
        end
        if (!i_rst_n) r_ovalid <= 1'b0;
        else r_ovalid <= n_ovalid;
    end
endmodule
`default_nettype wire

FILE: design/x86_instruction_length_decoder.sv
// Length decoder for 32-bit x86 code, one code byte per item at up to one item per cycle.
// A byte is classified and queued in the front part when accepted and later sequenced by
// the back part, which loads the output register when a byte completes an instruction.
// Throughput is one byte per cycle while results are taken; a two-entry queue decouples
// input stalls. Synchronous active-low reset empties the queue and output register.
// Depends on ild_pkg, ild_front and ild_back.
`default_nettype none
module x86_instruction_length_decoder #(
    parameter int MAX_INSTR_BYTES = ild_pkg::MAX_INSTR_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_code_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_instr_length,
    output logic [11:0]      o_decode_flags,
    output logic [2:0]       o_disp_length,
    output logic [2:0]       o_imm_length,
    output logic [7:0]       o_seg_prefix,
    output logic [7:0]       o_rep_prefix,
    output logic [7:0]       o_first_opcode,
    output logic [7:0]       o_second_opcode,
    output logic [7:0]       o_modrm_byte,
    output logic [7:0]       o_sib_byte,
    output logic [31:0]      o_disp_bytes,
    output logic [47:0]      o_imm_bytes
);
    ild_pkg::t_qout q;
    logic           pop;

    ild_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_code_byte(i_code_byte), .o_q(q), .i_pop(pop)
    );

    ild_back #(.MAX_INSTR_BYTES(MAX_INSTR_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q(q), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_instr_length(o_instr_length), .o_decode_flags(o_decode_flags),
        .o_disp_length(o_disp_length), .o_imm_length(o_imm_length),
        .o_seg_prefix(o_seg_prefix), .o_rep_prefix(o_rep_prefix),
        .o_first_opcode(o_first_opcode), .o_second_opcode(o_second_opcode),
        .o_modrm_byte(o_modrm_byte), .o_sib_byte(o_sib_byte),
        .o_disp_bytes(o_disp_bytes), .o_imm_bytes(o_imm_bytes)
    );

`ifndef ASSERT_OFF
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_instr_length != 4'd0 && o_instr_length <= 4'(MAX_INSTR_BYTES)))
        else $error("instruction length out of range");
    a_overlength: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_decode_flags[ild_pkg::F_OVER]) |->
        (o_instr_length == 4'(MAX_INSTR_BYTES) && o_disp_length == 3'd0 &&
         o_imm_length == 3'd0))
        else $error("overlength item with wrong lengths");
    a_field_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_disp_length <= 3'd4 && o_imm_length <= 3'd6))
        else $error("displacement or immediate length out of range");
`endif
endmodule
`default_nettype wire

FILE: tb/sv/x86_instruction_length_decoder_tb.sv
// Testbench for the x86 instruction length decoder: drives a code byte stream with random
// idling on both sides and checks every completed instruction against a built-in predictor.
// Depends on ild_pkg and x86_instruction_length_decoder.
`default_nettype none
module x86_instruction_length_decoder_tb;
    import ild_pkg::*;

    typedef struct packed {
        logic [3:0]  len;
        logic [11:0] flags;
        logic [2:0]  dlen;
        logic [2:0]  ilen;
        logic [7:0]  seg;
        logic [7:0]  rep;
        logic [7:0]  op1;
        logic [7:0]  op2;
        logic [7:0]  modrm;
        logic [7:0]  sib;
        logic [31:0] disp;
        logic [47:0] imm;
    } t_instr;

    typedef enum logic [2:0] {
        ST_OPC, ST_OPC2, ST_MODRM, ST_SIB, ST_DISP, ST_IMM
    } t_phase;

    int errors = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    class length_scoreboard;
        t_instr pending[$];
        t_phase ph;
        logic [11:0] fl;
        logic [3:0] cnt;
        logic [7:0] seg, rep, op1, op2, modrm, sib;
        logic [31:0] disp;
        logic [47:0] imm;
        logic [2:0] drem, irem;
        logic [1:0] sz;
        int instrs = 0;
        int overlong = 0;

        function void clear();
            ph = ST_OPC; fl = '0; cnt = '0; seg = '0; rep = '0; op1 = '0; op2 = '0;
            modrm = '0; sib = '0; disp = '0; imm = '0; drem = '0; irem = '0; sz = '0;
        endfunction

        function logic has_sib();
            return fl[F_MR] && !sz[1] && modrm[2:0] == 3'd4 && modrm[7:6] != 2'd3;
        endfunction

        function logic [2:0] disp_len();
            logic [2:0] n;
            n = 3'd0;
            if (!fl[F_MR]) return 3'd0;
            if (modrm[7:6] == 2'd0) begin
                if (sz[1] && modrm[2:0] == 3'd6) n = 3'd2;
                if (!sz[1] && modrm[2:0] == 3'd5) n = 3'd4;
            end else if (modrm[7:6] == 2'd1) begin
                n = 3'd1;
            end else if (modrm[7:6] == 2'd2) begin
                n = sz[1] ? 3'd2 : 3'd4;
            end
            if (has_sib() && sib[2:0] == 3'd5 && modrm[7:6] == 2'd0) n = 3'd4;
            return n;
        endfunction

        function logic [2:0] imm_len();
            logic [2:0] n;
            logic nar;
            nar = sz[0];
            if (!fl[F_TWO] && op1 >= B_MOFFS_LO && op1 <= B_MOFFS_HI) nar = sz[1];
            n = 3'd0;
            if (fl[F_I8]) n += 3'd1;
            if (fl[F_I16]) n += 3'd2;
            if (fl[F_IZ]) n += nar ? 3'd2 : 3'd4;
            return n;
        endfunction

        function logic tail();
            drem = disp_len();
            irem = imm_len();
            if (drem != 0) begin
                ph = ST_DISP;
                return 1'b0;
            end
            if (irem != 0) begin
                ph = ST_IMM;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function logic after_op();
            if (fl[F_MR]) begin
                ph = ST_MODRM;
                return 1'b0;
            end
            return tail();
        endfunction

        function void note_byte(input logic [7:0] b);
            logic done;
            int idx;
            t_instr r;
            done = 1'b0;
            cnt++;
            case (ph)
                ST_OPC: begin
                    if (b == B_P66) begin
                        fl[F_P66] = 1'b1; sz[0] = 1'b1;
                    end else if (b == B_P67) begin
                        fl[F_P67] = 1'b1; sz[1] = 1'b1;
                    end else if (b == B_LOCK) begin
                        fl[F_LOCK] = 1'b1;
                    end else if ((b & B_REPM) == B_REP) begin
                        fl[F_REP] = 1'b1; rep = b;
                    end else if (b == B_CS || b == B_SS || b == B_DS || b == B_ES ||
                                 b == B_FS || b == B_GS) begin
                        fl[F_SEG] = 1'b1; seg = b;
                    end else if (b == B_ESC) begin
                        op1 = b; fl[F_TWO] = 1'b1; ph = ST_OPC2;
                    end else begin
                        op1 = b;
                        fl[4:0] |= ONE_CLS[b];
                        done = after_op();
                    end
                end
                ST_OPC2: begin
                    op2 = b;
                    fl[4:0] |= TWO_CLS[b];
                    done = after_op();
                end
                ST_MODRM: begin
                    modrm = b;
                    if (!fl[F_TWO]) begin
                        if (op1 == B_TEST8 && b[5:3] == 3'd0) fl[F_I8] = 1'b1;
                        if (op1 == B_TESTZ && b[5:3] == 3'd0) fl[F_IZ] = 1'b1;
                        if (op1 == B_GRP5 && (b[5:3] == 3'd2 || b[5:3] == 3'd4))
                            fl[F_RB] = 1'b1;
                    end
                    if (has_sib()) ph = ST_SIB;
                    else done = tail();
                end
                ST_SIB: begin
                    sib = b;
                    done = tail();
                end
                ST_DISP: begin
                    idx = (disp_len() - drem) & 3;
                    disp |= 32'(b) << (8 * idx);
                    drem--;
                    if (drem == 0) begin
                        irem = imm_len();
                        if (irem != 0) ph = ST_IMM;
                        else done = 1'b1;
                    end
                end
                default: begin
                    idx = imm_len() - irem;
                    if (idx > 5) idx = 5;
                    imm |= 48'(b) << (8 * idx);
                    irem--;
                    if (irem == 0) done = 1'b1;
                end
            endcase
            r.dlen = '0;
            r.ilen = '0;
            if (done) begin
                r.dlen = disp_len();
                r.ilen = imm_len();
            end else if (cnt >= MAX_INSTR_BYTES) begin
                fl[F_OVER] = 1'b1;
                overlong++;
                done = 1'b1;
            end
            if (done) begin
                r.len = cnt; r.flags = fl; r.seg = seg; r.rep = rep; r.op1 = op1;
                r.op2 = op2; r.modrm = modrm; r.sib = sib; r.disp = disp; r.imm = imm;
                pending.push_back(r);
                clear();
            end
        endfunction

        task check(input t_instr got);
            t_instr w;
            if (pending.size() == 0) begin
                report("unexpected instruction, length", 64'(got.len), 64'(0));
                return;
            end
            w = pending.pop_front();
            instrs++;
            if (got.len !== w.len) report("instr_length", 64'(got.len), 64'(w.len));
            if (got.flags !== w.flags) report("decode_flags", 64'(got.flags), 64'(w.flags));
            if (got.dlen !== w.dlen) report("disp_length", 64'(got.dlen), 64'(w.dlen));
            if (got.ilen !== w.ilen) report("imm_length", 64'(got.ilen), 64'(w.ilen));
            if (got.seg !== w.seg) report("seg_prefix", 64'(got.seg), 64'(w.seg));
            if (got.rep !== w.rep) report("rep_prefix", 64'(got.rep), 64'(w.rep));
            if (got.op1 !== w.op1) report("first_opcode", 64'(got.op1), 64'(w.op1));
            if (got.op2 !== w.op2) report("second_opcode", 64'(got.op2), 64'(w.op2));
            if (got.modrm !== w.modrm) report("modrm_byte", 64'(got.modrm), 64'(w.modrm));
            if (got.sib !== w.sib) report("sib_byte", 64'(got.sib), 64'(w.sib));
            if (got.disp !== w.disp) report("disp_bytes", 64'(got.disp), 64'(w.disp));
            if (got.imm !== w.imm) report("imm_bytes", 64'(got.imm), 64'(w.imm));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic [7:0] i_code_byte = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall, o_out_valid;
    t_instr got;
    logic quiet = 1'b0;
    int idle_cycles = 0;
    int bytes_sent = 0;
    length_scoreboard sb;

    always #6 i_clk = ~i_clk;

    x86_instruction_length_decoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_code_byte(i_code_byte),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_instr_length(got.len), .o_decode_flags(got.flags),
        .o_disp_length(got.dlen), .o_imm_length(got.ilen),
        .o_seg_prefix(got.seg), .o_rep_prefix(got.rep),
        .o_first_opcode(got.op1), .o_second_opcode(got.op2),
        .o_modrm_byte(got.modrm), .o_sib_byte(got.sib),
        .o_disp_bytes(got.disp), .o_imm_bytes(got.imm)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check(got);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 2000) begin
                $display("watchdog expired with %0d instructions outstanding",
                         sb.pending.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver stalls in bursts, none once the quiet phase starts.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 11);
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_code_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_seq(input logic [7:0] s[$]);
        foreach (s[k]) send_byte(s[k]);
    endtask

    function automatic logic [7:0] pick_prefix();
        logic [7:0] p[10] = '{B_P66, B_P67, B_LOCK, 8'hF2, 8'hF3, B_CS, B_SS, B_DS, B_ES, B_FS};
        if ($urandom_range(0, 10) == 0) return B_GS;
        return p[$urandom_range(0, 9)];
    endfunction

    // A well-formed instruction: prefixes, opcode, then random bytes for the tail, which
    // the predictor sizes itself.
    task automatic send_random_instr();
        int np;
        logic [7:0] b;
        np = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        repeat (np) send_byte(pick_prefix());
        if ($urandom_range(0, 4) == 0) begin
            send_byte(B_ESC);
        end
        do begin
            b = 8'($urandom);
            if ($urandom_range(0, 5) == 0) b = B_TEST8 + 8'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) b = B_MOFFS_LO + 8'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) b = B_GRP5;
            send_byte(b);
        end while (sb.ph == ST_OPC && sb.cnt != 0);
        while (sb.cnt != 0) send_byte(8'($urandom));
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_seq('{8'h90});
        send_seq('{8'h00, 8'h04, 8'h25, 8'hEF, 8'hBE, 8'hAD, 8'hDE});
        send_seq('{8'h67, 8'h8B, 8'h06, 8'h34, 8'h12});
        send_seq('{8'h67, 8'hA1, 8'h78, 8'h56});
        send_seq('{8'h66, 8'hA1, 8'h01, 8'h02, 8'h03, 8'h04});
        send_seq('{8'hF7, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44, 8'hAA, 8'hBB, 8'hCC, 8'hDD});
        send_seq('{8'hF6, 8'hC0, 8'h7F});
        send_seq('{8'hFF, 8'h14, 8'h24});
        send_seq('{8'hC8, 8'hFF, 8'hFF, 8'hFF});
        send_seq('{8'h0F, 8'h84, 8'h00, 8'h00, 8'h00, 8'h80});
        send_seq('{8'h26, 8'h2E, 8'hF2, 8'hF3, B_GS, B_LOCK, 8'h36, 8'h3E, 8'h64, 8'h66,
                   8'h67, 8'h26, 8'h2E, 8'h36, 8'h3E, 8'h90});
        while (bytes_sent < 1340) begin
            if (bytes_sent > 1150) quiet = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                send_byte(8'($urandom));
            end else begin
                send_random_instr();
            end
        end
        // Flush any unfinished instruction so every byte produces a result.
        while (sb.cnt != 0) send_byte(8'h90);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("Checked %0d instructions from %0d code bytes, %0d of them overlength.",
                 sb.instrs, bytes_sent, sb.overlong);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
design/ild_pkg.sv
design/ild_front.sv
design/ild_back.sv
design/x86_instruction_length_decoder.sv
tb/sv/x86_instruction_length_decoder_tb.sv
